// File: rtl/tile_map_scaled_rasterizer_assert.svh
// assertion macros shared by the rasterizer modules
// each macro expects signals named clk and rst in the enclosing module
`ifndef TILE_MAP_SCALED_RASTERIZER_ASSERT_SVH
`define TILE_MAP_SCALED_RASTERIZER_ASSERT_SVH

// condition holds at every edge outside reset
`define TMSR_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// condition at one edge implies a result at the next edge
`define TMSR_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/tmsr_pkg.sv
// ----------------------------------------------------------------------------
// tmsr_pkg
// shared types and constants of the tile map scaled rasterizer
// ----------------------------------------------------------------------------
`default_nettype none

package tmsr_pkg;

  // map and scale limits
  localparam logic [8:0] MAX_TILES = 9'd256;
  localparam logic [3:0] MAX_SCALE = 4'd8;

  // colour constants
  localparam logic [31:0] DARK_COLOR   = 32'hFF1A2818;
  localparam logic [31:0] ALPHA_OPAQUE = 32'hFF000000;
  localparam logic [7:0]  RED_MUL      = 8'd47;
  localparam logic [7:0]  GREEN_MUL    = 8'd91;
  localparam logic [7:0]  GREEN_ADD    = 8'd40;
  localparam logic [7:0]  BLUE_MUL     = 8'd13;
  localparam logic [7:0]  BLUE_ADD     = 8'd60;

  // stream widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 56;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1,
    CFG_SCALE      = 2'd2
  } cfg_index_t;

  // configuration registers as seen by the front
  typedef struct packed {
    logic [8:0] map_width;
    logic [8:0] map_height;
    logic [3:0] scale;
  } cfg_t;

  // one cell to draw: start address, raster width, scale, colour
  typedef struct packed {
    logic [21:0] base;
    logic [11:0] rw;
    logic [3:0]  scale;
    logic [31:0] color;
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: rtl/tmsr_front.sv
// ----------------------------------------------------------------------------
// tmsr_front
// accepts tile cells, drops those that draw nothing, builds draw commands
// ----------------------------------------------------------------------------
`default_nettype none

module tmsr_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire tmsr_pkg::cfg_t                    cfg,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // layer_index, layer_width, layer_height, tile_x, tile_y, tile_id, zero pad
  input  wire logic [tmsr_pkg::IN_TDATA_W-1:0]   s_tdata,
  output logic                                   push,
  output tmsr_pkg::cell_cmd_t                    push_cmd,
  input  wire logic                              push_ready
);
  import tmsr_pkg::*;

  // input fields
  logic [7:0]  layer_index;
  logic [8:0]  layer_width;
  logic [8:0]  layer_height;
  logic [7:0]  tile_x;
  logic [7:0]  tile_y;
  logic [31:0] tile_id;

  assign layer_index  = s_tdata[7:0];
  assign layer_width  = s_tdata[16:8];
  assign layer_height = s_tdata[25:17];
  assign tile_x       = s_tdata[33:26];
  assign tile_y       = s_tdata[41:34];
  assign tile_id      = s_tdata[73:42];

  // clamped map size and scale
  logic [8:0]  w_eff;
  logic [8:0]  h_eff;
  logic [3:0]  s_eff;
  logic [11:0] rw_in;
  logic [10:0] tx_s_in;
  logic [10:0] ty_s_in;

  assign w_eff   = (cfg.map_width > MAX_TILES) ? MAX_TILES : cfg.map_width;
  assign h_eff   = (cfg.map_height > MAX_TILES) ? MAX_TILES : cfg.map_height;
  assign s_eff   = (cfg.scale > MAX_SCALE) ? MAX_SCALE : cfg.scale;
  assign rw_in   = 12'(w_eff) * 12'(s_eff);
  assign tx_s_in = 11'(tile_x) * 11'(s_eff);
  assign ty_s_in = 11'(tile_y) * 11'(s_eff);

  // cells that produce no writes
  logic skip;

  assign skip = ((tile_id == 32'd0) && (layer_index != 8'd0))
             || (layer_width != cfg.map_width) || (layer_height != cfg.map_height)
             || (cfg.map_width == 9'd0) || (cfg.map_height == 9'd0)
             || (cfg.scale == 4'd0)
             || (9'(tile_x) >= w_eff) || (9'(tile_y) >= h_eff);

  // colour hash of the low id bits
  logic [7:0]  g8;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [31:0] color_in;

  assign g8       = tile_id[7:0];
  assign red      = g8 * RED_MUL;
  assign green    = g8 * GREEN_MUL + GREEN_ADD;
  assign blue     = g8 * BLUE_MUL + BLUE_ADD;
  assign color_in = (tile_id == 32'd0) ? DARK_COLOR
                  : (ALPHA_OPAQUE | {8'd0, red, green, blue});

  // first stage registers
  logic        s1_valid;
  logic [10:0] s1_tx_s;
  logic [10:0] s1_ty_s;
  logic [11:0] s1_rw;
  logic [3:0]  s1_scale;
  logic [31:0] s1_color;
  logic        accept;

  assign s_tready = !s1_valid || push_ready;
  assign accept   = s_tvalid && s_tready;
  assign push     = s1_valid && push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= !skip;
    end else if (push) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_tx_s  <= tx_s_in;
      s1_ty_s  <= ty_s_in;
      s1_rw    <= rw_in;
      s1_scale <= s_eff;
      s1_color <= color_in;
    end
  end

  // start address of the cell: row times raster width plus column
  logic [21:0] row_prod;

  assign row_prod       = s1_ty_s * s1_rw;
  assign push_cmd.base  = row_prod + 22'(s1_tx_s);
  assign push_cmd.rw    = s1_rw;
  assign push_cmd.scale = s1_scale;
  assign push_cmd.color = s1_color;

endmodule

`default_nettype wire

// File: rtl/tmsr_queue.sv
// ----------------------------------------------------------------------------
// tmsr_queue
// short command queue that decouples the front from the back
// ----------------------------------------------------------------------------
`default_nettype none

module tmsr_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire tmsr_pkg::cell_cmd_t  push_cmd,
  output logic                      push_ready,
  input  wire logic                 pop,
  output tmsr_pkg::cell_cmd_t       pop_cmd,
  output logic                      pop_valid
);
  import tmsr_pkg::*;

  `include "tile_map_scaled_rasterizer_assert.svh"

  cell_cmd_t           entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QUEUE_CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  `TMSR_ASSERT_ALWAYS(a_count_bound, count <= QUEUE_CW'(QUEUE_DEPTH), "queue count overflow")
  `TMSR_ASSERT_NEXT(a_count_up, do_push && !do_pop, count == $past(count) + 1'b1, "count not incremented")
  `TMSR_ASSERT_ALWAYS(a_ptr_gap, QUEUE_AW'(wr_ptr - rd_ptr) == QUEUE_AW'(count), "pointers disagree with count")

endmodule

`default_nettype wire

// File: rtl/tmsr_back.sv
// ----------------------------------------------------------------------------
// tmsr_back
// walks each cell's square row by row, one pixel word per cycle unless stalled
// ----------------------------------------------------------------------------
`default_nettype none

module tmsr_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire tmsr_pkg::cell_cmd_t                pop_cmd,
  input  wire logic                               pop_valid,
  output logic                                    pop,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // pixel_address, pixel_color, zero pad
  output logic [tmsr_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                    m_tlast
);
  import tmsr_pkg::*;

  `include "tile_map_scaled_rasterizer_assert.svh"

  // current cell
  logic        active;
  logic [21:0] cur_addr;
  logic [21:0] row_addr;
  logic [11:0] cur_rw;
  logic [3:0]  cur_s;
  logic [31:0] cur_color;
  logic [2:0]  sx;
  logic [2:0]  sy;

  logic row_end;
  logic last_px;
  logic emit;
  logic cell_done;

  assign row_end   = (4'(sx) == cur_s - 4'd1);
  assign last_px   = row_end && (4'(sy) == cur_s - 4'd1);
  assign emit      = active && (!m_tvalid || m_tready);
  assign cell_done = emit && last_px;
  assign pop       = pop_valid && (!active || cell_done);

  // walk control and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      active   <= 1'b0;
      m_tvalid <= 1'b0;
      sx       <= '0;
      sy       <= '0;
    end else begin
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        active <= 1'b1;
        sx     <= '0;
        sy     <= '0;
      end else if (cell_done) begin
        active <= 1'b0;
      end else if (emit) begin
        if (row_end) begin
          sx <= '0;
          sy <= sy + 1'b1;
        end else begin
          sx <= sx + 1'b1;
        end
      end
    end
  end

  // addresses, cell payload and output word
  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= {2'b00, cur_color, cur_addr};
      m_tlast <= last_px;
    end
    if (pop) begin
      cur_addr  <= pop_cmd.base;
      row_addr  <= pop_cmd.base;
      cur_rw    <= pop_cmd.rw;
      cur_s     <= pop_cmd.scale;
      cur_color <= pop_cmd.color;
    end else if (emit && !last_px) begin
      if (row_end) begin
        cur_addr <= row_addr + 22'(cur_rw);
        row_addr <= row_addr + 22'(cur_rw);
      end else begin
        cur_addr <= cur_addr + 22'd1;
      end
    end
  end

  `TMSR_ASSERT_ALWAYS(a_sx_range, !active || (4'(sx) < cur_s), "column counter beyond scale")
  `TMSR_ASSERT_ALWAYS(a_sy_range, !active || (4'(sy) < cur_s), "row counter beyond scale")
  `TMSR_ASSERT_NEXT(a_pop_loads, pop, active && sx == 3'd0 && sy == 3'd0, "cell not loaded on pop")

endmodule

`default_nettype wire

// File: rtl/tile_map_scaled_rasterizer.sv
// ----------------------------------------------------------------------------
// tile_map_scaled_rasterizer
// draws tile cells as scale-by-scale squares of pixel writes
// ----------------------------------------------------------------------------
// usage:
// - s_t* carries one tile cell per word; cells that draw nothing (empty cell
//   above the base layer, layer size unlike the map, zero size or scale, cell
//   outside the map) are taken and produce no writes
// - m_t* carries pixel writes: address and colour in tdata, tlast on the
//   final write of a cell; writes leave row by row, column inner
// - cfg_we/cfg_index/cfg_data write map_width, map_height and scale; the user
//   must write them only while the block is idle (not enforced); no read-back
// - a drawn cell gives scale*scale writes at one write per cycle while the
//   receiver is ready, paced by the back end's pixel walker; cells follow
//   each other with no gap when the next one is already queued
// - a cell's first write passes the front stage, the command queue and the
//   walker into the output register, and can wait behind earlier cells
// - a four-entry command queue lets the front keep accepting cells while the
//   receiver stalls; when it and the front stage are full, s_tready drops
// - synchronous reset empties the pipeline and sets the config registers to 1
// ----------------------------------------------------------------------------
`default_nettype none

module tile_map_scaled_rasterizer (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_index,
  input  wire logic [8:0]                         cfg_data,
  input  wire logic                               s_tvalid,
  output logic                                    s_tready,
  // layer_index, layer_width, layer_height, tile_x, tile_y, tile_id, zero pad
  input  wire logic [tmsr_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                    m_tvalid,
  input  wire logic                               m_tready,
  // pixel_address, pixel_color, zero pad
  output logic [tmsr_pkg::OUT_TDATA_W-1:0]        m_tdata,
  output logic                                    m_tlast
);
  import tmsr_pkg::*;

  // configuration registers
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.map_width  <= 9'd1;
      cfg.map_height <= 9'd1;
      cfg.scale      <= 4'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAP_WIDTH:  cfg.map_width  <= cfg_data;
        CFG_MAP_HEIGHT: cfg.map_height <= cfg_data;
        CFG_SCALE:      cfg.scale      <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic      push;
  logic      push_ready;
  cell_cmd_t push_cmd;
  logic      pop;
  logic      pop_valid;
  cell_cmd_t pop_cmd;

  tmsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  tmsr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .pop_valid  (pop_valid)
  );

  tmsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_cmd   (pop_cmd),
    .pop_valid (pop_valid),
    .pop       (pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

`default_nettype wire

// File: tb/sv/tmsr_pixel_checker.sv
// ----------------------------------------------------------------------------
// tmsr_pixel_checker
// watches the config port and both streams of the tile map rasterizer,
// predicts the pixel writes of every accepted cell and compares each write
// leaving the block with the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tmsr_pixel_checker (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_index,
  input  wire logic [8:0]                       cfg_data,
  input  wire logic                             s_tvalid,
  input  wire logic                             s_tready,
  // layer_index, layer_width, layer_height, tile_x, tile_y, tile_id, zero pad
  input  wire logic [tmsr_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                             m_tvalid,
  input  wire logic                             m_tready,
  // pixel_address, pixel_color, zero pad
  input  wire logic [tmsr_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  wire logic                             m_tlast,
  output int                                    error_count,
  output int                                    writes_pending
);
  import tmsr_pkg::*;

  typedef struct packed {
    logic [21:0] addr;
    logic [31:0] color;
    logic        last;
  } pixel_write_t;

  pixel_write_t pixel_queue[$];
  logic [8:0]   map_w;
  logic [8:0]   map_h;
  logic [3:0]   map_scale;
  int           fail_tally = 0;

  // expected writes of one cell, appended to the queue
  function automatic void predict_cell(input logic [IN_TDATA_W-1:0] word);
    logic [7:0]   layer;
    logic [8:0]   lw;
    logic [8:0]   lh;
    logic [7:0]   tx;
    logic [7:0]   ty;
    logic [31:0]  id;
    logic [15:0]  g;
    logic [7:0]   red;
    logic [7:0]   green;
    logic [7:0]   blue;
    logic [31:0]  color;
    int unsigned  w;
    int unsigned  h;
    int unsigned  s;
    int unsigned  rw;
    int unsigned  sx;
    int unsigned  sy;
    pixel_write_t pw;
    layer = word[7:0];
    lw    = word[16:8];
    lh    = word[25:17];
    tx    = word[33:26];
    ty    = word[41:34];
    id    = word[73:42];
    // skipped cells
    if (id == 32'd0 && layer != 8'd0) return;
    if (lw != map_w || lh != map_h) return;
    if (map_w == 9'd0 || map_h == 9'd0 || map_scale == 4'd0) return;
    w = (map_w > MAX_TILES) ? MAX_TILES : map_w;
    h = (map_h > MAX_TILES) ? MAX_TILES : map_h;
    s = (map_scale > MAX_SCALE) ? MAX_SCALE : map_scale;
    if (tx >= w || ty >= h) return;
    // colour from the low half of the id
    if (id == 32'd0) begin
      color = DARK_COLOR;
    end else begin
      g     = id[15:0];
      red   = 8'(g * RED_MUL);
      green = 8'(g * GREEN_MUL + GREEN_ADD);
      blue  = 8'(g * BLUE_MUL + BLUE_ADD);
      color = ALPHA_OPAQUE | {8'd0, red, green, blue};
    end
    // square of writes, row by row
    rw = w * s;
    for (sy = 0; sy < s; sy++) begin
      for (sx = 0; sx < s; sx++) begin
        pw.addr  = 22'((ty * s + sy) * rw + tx * s + sx);
        pw.color = color;
        pw.last  = (sy == s - 1) && (sx == s - 1);
        pixel_queue.push_back(pw);
      end
    end
  endfunction

  always @(posedge clk) begin
    pixel_write_t exp_w;
    if (rst) begin
      map_w     = 9'd1;
      map_h     = 9'd1;
      map_scale = 4'd1;
      pixel_queue.delete();
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_MAP_WIDTH:  map_w = cfg_data;
          CFG_MAP_HEIGHT: map_h = cfg_data;
          CFG_SCALE:      map_scale = cfg_data[3:0];
          default: ;
        endcase
      end
      // accepted cell
      if (s_tvalid && s_tready) predict_cell(s_tdata);
      // accepted pixel write
      if (m_tvalid && m_tready) begin
        if (pixel_queue.size() == 0) begin
          $error("unexpected pixel write: address %0d color %08h last %0b",
                 m_tdata[21:0], m_tdata[53:22], m_tlast);
          fail_tally++;
        end else begin
          exp_w = pixel_queue.pop_front();
          if (m_tdata[21:0] !== exp_w.addr) begin
            $error("pixel_address: expected %0d, actual %0d", exp_w.addr, m_tdata[21:0]);
            fail_tally++;
          end
          if (m_tdata[53:22] !== exp_w.color) begin
            $error("pixel_color: expected %08h, actual %08h", exp_w.color, m_tdata[53:22]);
            fail_tally++;
          end
          if (m_tlast !== exp_w.last) begin
            $error("last_write: expected %0b, actual %0b", exp_w.last, m_tlast);
            fail_tally++;
          end
        end
      end
    end
    error_count    <= fail_tally;
    writes_pending <= pixel_queue.size();
  end

endmodule

`default_nettype wire

// File: tb/sv/tb_tile_map_scaled_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_tile_map_scaled_rasterizer
// drives cells into the rasterizer under a range of map sizes and scales,
// first hand-picked corner cells, then mostly well-formed random cells with
// some noise, while both stream sides idle and stall at random; a separate
// checker predicts and compares the pixel writes
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_tile_map_scaled_rasterizer;
  import tmsr_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  cfg_index_t             cfg_index = CFG_MAP_WIDTH;
  logic [8:0]             cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // layer_index, layer_width, layer_height, tile_x, tile_y, tile_id, zero pad
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // pixel_address, pixel_color, zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  int                     error_count;
  int                     writes_pending;

  int                     idle_pct = 0;
  int                     stall_pct = 0;
  logic [8:0]             cur_w = 9'd1;
  logic [8:0]             cur_h = 9'd1;
  logic [3:0]             cur_scale = 4'd1;

  tile_map_scaled_rasterizer DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  tmsr_pixel_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tlast        (m_tlast),
    .error_count    (error_count),
    .writes_pending (writes_pending)
  );

  always #5 clk = ~clk;

  // receiver backpressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // all three registers, one per cycle; upper data bits of scale are don't-care
  task automatic set_config(input logic [8:0] w, input logic [8:0] h, input logic [3:0] sc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAP_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_MAP_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_SCALE;
    cfg_data  <= {5'($urandom), sc};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_w     = w;
    cur_h     = h;
    cur_scale = sc;
  endtask

  // one cell word, with an optional random gap in front
  task automatic send_cell(input logic [7:0] layer, input logic [8:0] lw,
                           input logic [8:0] lh, input logic [7:0] tx,
                           input logic [7:0] ty, input logic [31:0] id);
    if ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, id, ty, tx, lh, lw, layer};
    do @(posedge clk); while (!s_tready);
  endtask

  // mostly cells that draw, the rest noise
  task automatic send_random_cell();
    int unsigned w_eff;
    int unsigned h_eff;
    int unsigned r;
    logic [31:0] id;
    w_eff = (cur_w > 9'd256) ? 256 : cur_w;
    h_eff = (cur_h > 9'd256) ? 256 : cur_h;
    r = $urandom_range(99);
    case ($urandom_range(9))
      0:       id = 32'd0;
      1, 2:    id = $urandom_range(65535);
      default: id = $urandom;
    endcase
    if (r < 80 && w_eff != 0 && h_eff != 0) begin
      send_cell(($urandom_range(2) == 0) ? 8'd0 : 8'($urandom), cur_w, cur_h,
                8'($urandom_range(w_eff - 1)), 8'($urandom_range(h_eff - 1)), id);
    end else if (r < 90) begin
      send_cell(8'($urandom), cur_w, cur_h, 8'($urandom), 8'($urandom), id);
    end else begin
      send_cell(8'($urandom), 9'($urandom), 9'($urandom), 8'($urandom),
                8'($urandom), id);
    end
  endtask

  // wait until every predicted write has left, plus the pipeline depth
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (writes_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    logic [8:0] w;
    logic [8:0] h;
    logic [3:0] sc;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: dark colour, full id, empty above base, mismatch, outside
    send_cell(8'd0, 9'd1, 9'd1, 8'd0, 8'd0, 32'd0);
    send_cell(8'd255, 9'd1, 9'd1, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_cell(8'd1, 9'd1, 9'd1, 8'd0, 8'd0, 32'd0);
    send_cell(8'd0, 9'd2, 9'd1, 8'd0, 8'd0, 32'd5);
    send_cell(8'd0, 9'd1, 9'd1, 8'd1, 8'd0, 32'd7);
    send_cell(8'd0, 9'd1, 9'd1, 8'd0, 8'd1, 32'd7);
    drain();
    // largest map and scale, far corner reaches the top address
    set_config(9'd256, 9'd256, 4'd8);
    send_cell(8'd0, 9'd256, 9'd256, 8'd255, 8'd255, 32'h1234_5678);
    send_cell(8'd128, 9'd256, 9'd256, 8'd0, 8'd0, 32'hFFFF_0000);
    send_cell(8'd3, 9'd256, 9'd256, 8'd170, 8'd85, 32'hA5A5_A5A5);
    drain();
    // small map: edges, outside, height mismatch
    set_config(9'd5, 9'd3, 4'd2);
    send_cell(8'd2, 9'd5, 9'd3, 8'd4, 8'd2, 32'd9);
    send_cell(8'd0, 9'd5, 9'd3, 8'd5, 8'd0, 32'd9);
    send_cell(8'd0, 9'd5, 9'd3, 8'd0, 8'd3, 32'd9);
    send_cell(8'd0, 9'd5, 9'd4, 8'd0, 8'd0, 32'd9);
    drain();
    // zero width, zero height, zero scale
    set_config(9'd0, 9'd3, 4'd2);
    send_cell(8'd0, 9'd0, 9'd3, 8'd0, 8'd0, 32'd1);
    drain();
    set_config(9'd3, 9'd0, 4'd1);
    send_cell(8'd0, 9'd3, 9'd0, 8'd0, 8'd0, 32'd1);
    drain();
    set_config(9'd4, 9'd4, 4'd0);
    send_cell(8'd0, 9'd4, 9'd4, 8'd1, 8'd1, 32'd1);
    drain();
    // scale above the limit behaves as the limit
    set_config(9'd4, 9'd4, 4'd15);
    send_cell(8'd0, 9'd4, 9'd4, 8'd3, 8'd3, 32'h0000_BEEF);
    drain();
    // map above the limit: clamped for raster and bounds, raw for size test
    set_config(9'd300, 9'd511, 4'd3);
    send_cell(8'd0, 9'd300, 9'd511, 8'd255, 8'd255, 32'h0000_55AA);
    send_cell(8'd0, 9'd300, 9'd511, 8'd0, 8'd0, 32'd1);
    drain();

    // random phases, cycling through the idle and stall mixes
    for (int phase = 0; phase < 8; phase++) begin
      case ($urandom_range(9))
        0:       w = 9'd256;
        1:       w = 9'($urandom);
        default: w = 9'($urandom_range(1, 32));
      endcase
      case ($urandom_range(9))
        0:       h = 9'd256;
        1:       h = 9'($urandom);
        default: h = 9'($urandom_range(1, 32));
      endcase
      case ($urandom_range(9))
        0:       sc = 4'd8;
        1:       sc = 4'($urandom);
        default: sc = 4'($urandom_range(1, 4));
      endcase
      set_config(w, h, sc);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 84; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 84; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      repeat (27) send_random_cell();
      drain();
    end

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
